// ===== rtl/core/ssfg_pkg.sv =====
package ssfg_pkg;

    // command codes
    localparam logic CMD_INIT = 1'b0;
    localparam logic CMD_SHOW = 1'b1;

    // marker selector codes
    localparam logic [1:0] MARK_H = 2'd1;
    localparam logic [1:0] MARK_C = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_INTENSITY   = 2'd0;
    localparam logic [1:0] CFG_SCAN_LIMIT  = 2'd1;
    localparam logic [1:0] CFG_DECODE_MASK = 2'd2;

    // display controller register addresses
    localparam logic [3:0] REG_NOOP      = 4'h0;
    localparam logic [3:0] REG_DIGIT1    = 4'h1;
    localparam logic [3:0] REG_DIGIT2    = 4'h2;
    localparam logic [3:0] REG_DIGIT3    = 4'h3;
    localparam logic [3:0] REG_DIGIT4    = 4'h4;
    localparam logic [3:0] REG_DIGIT8    = 4'h8;
    localparam logic [3:0] REG_DECODE    = 4'h9;
    localparam logic [3:0] REG_INTENSITY = 4'hA;
    localparam logic [3:0] REG_SCANLIM   = 4'hB;
    localparam logic [3:0] REG_SHUTDOWN  = 4'hC;
    localparam logic [3:0] REG_TEST      = 4'hF;

    // data bytes
    localparam logic [7:0] DATA_POWER_ON = 8'hFF;
    localparam logic [7:0] DATA_ZERO     = 8'h00;
    localparam logic [7:0] GLYPH_H       = 8'h37;
    localparam logic [7:0] GLYPH_C       = 8'h4E;
    localparam logic [3:0] CODE_BLANK    = 4'hF;

    localparam logic [13:0] VALUE_MAX = 14'd9999;

    // frame positions inside the init burst
    localparam logic [3:0] INIT_POWER       = 4'd0;
    localparam logic [3:0] INIT_DECODE      = 4'd1;
    localparam logic [3:0] INIT_TEST        = 4'd2;
    localparam logic [3:0] INIT_SCANLIM     = 4'd3;
    localparam logic [3:0] INIT_INTENSITY   = 4'd4;
    localparam logic [3:0] INIT_DIGIT_BASE  = 4'd4;
    localparam logic [3:0] INIT_CLEAR_FIRST = 4'd9;
    localparam logic [3:0] INIT_LAST        = 4'd12;

    // frame positions inside the show burst
    localparam logic [3:0] SHOW_MARK  = 4'd0;
    localparam logic [3:0] SHOW_THOU  = 4'd1;
    localparam logic [3:0] SHOW_HUND  = 4'd2;
    localparam logic [3:0] SHOW_TENS  = 4'd3;
    localparam logic [3:0] SHOW_LAST  = 4'd4;

    // one queued job: command, marker and decimal digits of the value
    typedef struct packed {
        logic       cmd;
        logic [1:0] marker;
        logic [3:0] d3;
        logic [3:0] d2;
        logic [3:0] d1;
        logic [3:0] d0;
    } t_job;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_status;

    typedef struct packed {
        logic [3:0] intensity;
        logic [2:0] scan_limit;
        logic [7:0] decode_mask;
    } t_cfg;

    typedef struct packed {
        logic [3:0]  dig;
        logic [13:0] rem;
    } t_step;

    // one decimal digit off the top: parallel compares against k*unit
    function automatic t_step digit_step(logic [13:0] rem, logic [13:0] unit);
        t_step s;
        s.dig = 4'd0;
        s.rem = rem;
        for (int k = 1; k <= 9; k++) begin
            if (rem >= 14'(k) * unit) begin
                s.dig = 4'(k);
                s.rem = rem - 14'(k) * unit;
            end
        end
        return s;
    endfunction

endpackage

// ===== rtl/core/seven_segment_frame_generator.sv =====
// the first frame of an item passes the front states THOU, HUND and TENS, the job
// queue and the output beat register; the back emits one frame per cycle while the
// output is not stalled; an init item is 13 frames, a show item 5
// the front converts a value one digit per state and queues jobs ahead of the back
// reset: synchronous, active low; clears queue, sequencer and front state,
// and loads intensity 0, scan limit 7, decode mask 0x0F
module seven_segment_frame_generator #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_cmd,
    input  logic [13:0] i_value,
    input  logic [1:0]  i_marker,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [15:0] o_frame,
    output logic        o_last,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    ssfg_pkg::t_cfg      r_cfg;
    ssfg_pkg::t_job      w_push_job, w_head;
    ssfg_pkg::t_q_status w_q_status;
    logic                w_push, w_pop;

    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.intensity   <= 4'd0;
            r_cfg.scan_limit  <= 3'd7;
            r_cfg.decode_mask <= 8'h0F;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                ssfg_pkg::CFG_INTENSITY:   r_cfg.intensity   <= i_cfg_data[3:0];
                ssfg_pkg::CFG_SCAN_LIMIT:  r_cfg.scan_limit  <= i_cfg_data[2:0];
                ssfg_pkg::CFG_DECODE_MASK: r_cfg.decode_mask <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // front: accept and convert
    ssfg_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_cmd      (i_cmd),
        .i_value    (i_value),
        .i_marker   (i_marker),
        .i_q_status (w_q_status),
        .o_push     (w_push),
        .o_job      (w_push_job)
    );

    // job queue between front and back
    ssfg_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_job    (w_push_job),
        .i_pop    (w_pop),
        .o_head   (w_head),
        .o_status (w_q_status)
    );

    // back: frame sequencer
    ssfg_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_head      (w_head),
        .i_q_status  (w_q_status),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_frame     (o_frame),
        .o_last      (o_last)
    );

`ifndef SYNTHESIS
    // no push into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_push && w_q_status.full))
        else $error("job pushed into full queue");

    // a burst ends on digit 8 (init) or digit 1 (show)
    a_last_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_last) |->
        (o_frame[11:8] == ssfg_pkg::REG_DIGIT8 || o_frame[11:8] == ssfg_pkg::REG_DIGIT1))
        else $error("final frame has wrong address");

    // a burst is never broken by a gap
    a_no_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_last && !i_out_stall) |=> o_out_valid)
        else $error("gap inside a frame burst");
`endif

endmodule

// ===== rtl/core/ssfg_front.sv =====
module ssfg_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_cmd,
    input  logic [13:0]           i_value,
    input  logic [1:0]            i_marker,
    input  ssfg_pkg::t_q_status   i_q_status,
    output logic                  o_push,
    output ssfg_pkg::t_job        o_job
);

    typedef enum logic [3:0] {
        F_IDLE = 4'b0001,
        F_THOU = 4'b0010,
        F_HUND = 4'b0100,
        F_TENS = 4'b1000
    } t_fstate;

    t_fstate        r_state, n_state;
    logic           r_cmd;
    logic [1:0]     r_marker;
    logic [13:0]    r_rem, n_rem;
    logic [3:0]     r_d3, r_d2;
    logic           w_accept;
    ssfg_pkg::t_step w_step_thou, w_step_hund, w_step_tens;
    logic [13:0]    w_sat;

    // digit extraction, one decimal position per cycle
    assign w_step_thou = ssfg_pkg::digit_step(r_rem, 14'd1000);
    assign w_step_hund = ssfg_pkg::digit_step(r_rem, 14'd100);
    assign w_step_tens = ssfg_pkg::digit_step(r_rem, 14'd10);

    assign w_sat = (i_value > ssfg_pkg::VALUE_MAX) ? ssfg_pkg::VALUE_MAX : i_value;

    // push the finished job; a new beat may enter in the same cycle
    assign o_push     = (r_state == F_TENS) && !i_q_status.full;
    assign w_accept   = i_in_valid && ((r_state == F_IDLE) || o_push);
    assign o_in_stall = !((r_state == F_IDLE) || o_push);

    assign o_job.cmd    = r_cmd;
    assign o_job.marker = r_marker;
    assign o_job.d3     = r_d3;
    assign o_job.d2     = r_d2;
    assign o_job.d1     = w_step_tens.dig;
    assign o_job.d0     = w_step_tens.rem[3:0];

    // next state
    always_comb begin
        n_state = r_state;
        n_rem   = r_rem;
        unique case (r_state)
            F_IDLE: begin
                if (w_accept) begin
                    n_state = F_THOU;
                    n_rem   = w_sat;
                end
            end
            F_THOU: begin
                n_state = F_HUND;
                n_rem   = w_step_thou.rem;
            end
            F_HUND: begin
                n_state = F_TENS;
                n_rem   = w_step_hund.rem;
            end
            F_TENS: begin
                if (w_accept) begin
                    n_state = F_THOU;
                    n_rem   = w_sat;
                end else if (o_push) begin
                    n_state = F_IDLE;
                end
            end
            default: begin
                n_state = F_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        if (w_accept) begin
            r_cmd    <= i_cmd;
            r_marker <= i_marker;
        end
        if (r_state == F_THOU) begin
            r_d3 <= w_step_thou.dig;
        end
        if (r_state == F_HUND) begin
            r_d2 <= w_step_hund.dig;
        end
    end

endmodule

// ===== rtl/core/ssfg_queue.sv =====
module ssfg_queue #(
    parameter int DEPTH = 2
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  ssfg_pkg::t_job      i_job,
    input  logic                i_pop,
    output ssfg_pkg::t_job      o_head,
    output ssfg_pkg::t_q_status o_status
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    ssfg_pkg::t_job r_mem [DEPTH];
    logic [PW-1:0]  r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]  r_count;

    assign o_head         = r_mem[r_rd_ptr];
    assign o_status.empty = (r_count == '0);
    assign o_status.full  = (r_count == CW'(DEPTH));

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

// ===== rtl/core/ssfg_back.sv =====
module ssfg_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ssfg_pkg::t_cfg      i_cfg,
    input  ssfg_pkg::t_job      i_head,
    input  ssfg_pkg::t_q_status i_q_status,
    output logic                o_pop,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [15:0]         o_frame,
    output logic                o_last
);

    logic        r_valid;
    logic [15:0] r_frame;
    logic        r_last;
    logic [3:0]  r_idx;
    logic        w_load, w_fire;
    logic [3:0]  w_addr;
    logic [7:0]  w_data;
    logic        w_last;
    logic [3:0]  w_c3, w_c2, w_c1;

    assign w_load = !r_valid || !i_out_stall;
    assign w_fire = w_load && !i_q_status.empty;
    assign o_pop  = w_fire && w_last;

    // leading-zero blanking above the units digit
    assign w_c3 = (i_head.d3 == 4'd0) ? ssfg_pkg::CODE_BLANK : i_head.d3;
    assign w_c2 = ((i_head.d3 == 4'd0) && (i_head.d2 == 4'd0)) ?
                  ssfg_pkg::CODE_BLANK : i_head.d2;
    assign w_c1 = ((i_head.d3 == 4'd0) && (i_head.d2 == 4'd0) && (i_head.d1 == 4'd0)) ?
                  ssfg_pkg::CODE_BLANK : i_head.d1;

    // frame selection by burst position
    always_comb begin
        w_addr = ssfg_pkg::REG_NOOP;
        w_data = ssfg_pkg::DATA_ZERO;
        if (i_head.cmd == ssfg_pkg::CMD_INIT) begin
            w_last = (r_idx == ssfg_pkg::INIT_LAST);
            unique case (r_idx)
                ssfg_pkg::INIT_POWER: begin
                    w_addr = ssfg_pkg::REG_SHUTDOWN;
                    w_data = ssfg_pkg::DATA_POWER_ON;
                end
                ssfg_pkg::INIT_DECODE: begin
                    w_addr = ssfg_pkg::REG_DECODE;
                    w_data = i_cfg.decode_mask;
                end
                ssfg_pkg::INIT_TEST: begin
                    w_addr = ssfg_pkg::REG_TEST;
                    w_data = ssfg_pkg::DATA_ZERO;
                end
                ssfg_pkg::INIT_SCANLIM: begin
                    w_addr = ssfg_pkg::REG_SCANLIM;
                    w_data = {5'd0, i_cfg.scan_limit};
                end
                ssfg_pkg::INIT_INTENSITY: begin
                    w_addr = ssfg_pkg::REG_INTENSITY;
                    w_data = {4'd0, i_cfg.intensity};
                end
                default: begin
                    w_addr = r_idx - ssfg_pkg::INIT_DIGIT_BASE;
                    w_data = (r_idx < ssfg_pkg::INIT_CLEAR_FIRST) ?
                             {4'd0, ssfg_pkg::CODE_BLANK} : ssfg_pkg::DATA_ZERO;
                end
            endcase
        end else begin
            w_last = (r_idx == ssfg_pkg::SHOW_LAST);
            unique case (r_idx)
                ssfg_pkg::SHOW_MARK: begin
                    unique if (i_head.marker == ssfg_pkg::MARK_H) begin
                        w_addr = ssfg_pkg::REG_DIGIT8;
                        w_data = ssfg_pkg::GLYPH_H;
                    end else if (i_head.marker == ssfg_pkg::MARK_C) begin
                        w_addr = ssfg_pkg::REG_DIGIT8;
                        w_data = ssfg_pkg::GLYPH_C;
                    end else begin
                        w_addr = ssfg_pkg::REG_NOOP;
                        w_data = ssfg_pkg::DATA_ZERO;
                    end
                end
                ssfg_pkg::SHOW_THOU: begin
                    w_addr = ssfg_pkg::REG_DIGIT4;
                    w_data = {4'd0, w_c3};
                end
                ssfg_pkg::SHOW_HUND: begin
                    w_addr = ssfg_pkg::REG_DIGIT3;
                    w_data = {4'd0, w_c2};
                end
                ssfg_pkg::SHOW_TENS: begin
                    w_addr = ssfg_pkg::REG_DIGIT2;
                    w_data = {4'd0, w_c1};
                end
                default: begin
                    w_addr = ssfg_pkg::REG_DIGIT1;
                    w_data = {4'd0, i_head.d0};
                end
            endcase
        end
    end

    // burst position and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            if (w_load) begin
                r_valid <= !i_q_status.empty;
            end
            if (w_fire) begin
                r_idx <= w_last ? 4'd0 : r_idx + 4'd1;
            end
        end
    end

    // output beat register
    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_frame <= {4'd0, w_addr, w_data};
            r_last  <= w_last;
        end
    end

    assign o_out_valid = r_valid;
    assign o_frame     = r_frame;
    assign o_last      = r_last;

endmodule

// ===== tb/seven_segment_frame_generator_tb.sv =====
`timescale 1ns / 100ps

module seven_segment_frame_generator_tb;

    localparam int unsigned RUN_LIMIT_NS  = 5_000_000;
    localparam int          DRAIN_CYCLES  = 16;
    localparam int          HOLD_CYCLES   = 400;
    localparam int          ITEMS_PER_SET = 100;
    localparam int          NUM_ROWS      = 19;

    // selector codes and register index with no meaning of their own
    localparam logic [1:0] MARK_NOOP  = 2'd0;
    localparam logic [1:0] MARK_OTHER = 2'd3;
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH, IDLE_PRESSURE} t_idle_mode;

    typedef struct {
        logic [15:0] frame;
        logic        last;
    } t_disp_frame;

    // one directed beat; mark and units are typed in where the row is easy to read off
    typedef struct {
        logic        cmd;
        logic [13:0] value;
        logic [1:0]  marker;
        bit          typed;
        logic [15:0] mark;
        logic [15:0] units;
    } t_stim_row;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic        o_in_stall;
    logic        i_cmd       = 1'b0;
    logic [13:0] i_value     = '0;
    logic [1:0]  i_marker    = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [15:0] o_frame;
    logic        o_last;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [7:0]  i_cfg_data  = '0;

    // predictor copy of the registers
    logic [3:0] cfg_intensity = 4'd0;
    logic [2:0] cfg_scan      = 3'd7;
    logic [7:0] cfg_decode    = 8'h0F;

    t_disp_frame pending_frames[$];
    t_idle_mode  idle_mode = IDLE_NONE;
    int          err_count    = 0;
    int          beats_sent   = 0;
    int          inits_sent   = 0;
    int          frames_seen  = 0;
    int          reg_writes   = 0;
    int          hold_left    = 0;
    bit          hold_done    = 1'b0;

    t_stim_row directed_rows [NUM_ROWS] = '{
        '{ssfg_pkg::CMD_INIT, 14'd0,     MARK_NOOP,        1'b0, 16'h0000, 16'h0000},
        '{ssfg_pkg::CMD_SHOW, 14'd0,     MARK_NOOP,        1'b1, 16'h0000, 16'h0100},
        '{ssfg_pkg::CMD_SHOW, 14'd9999,  ssfg_pkg::MARK_H, 1'b1, 16'h0837, 16'h0109},
        '{ssfg_pkg::CMD_SHOW, 14'd16383, ssfg_pkg::MARK_C, 1'b1, 16'h084E, 16'h0109},
        '{ssfg_pkg::CMD_SHOW, 14'd10000, MARK_OTHER,       1'b1, 16'h0000, 16'h0109},
        '{ssfg_pkg::CMD_SHOW, 14'd9,     ssfg_pkg::MARK_H, 1'b1, 16'h0837, 16'h0109},
        '{ssfg_pkg::CMD_SHOW, 14'd10,    ssfg_pkg::MARK_C, 1'b1, 16'h084E, 16'h0100},
        '{ssfg_pkg::CMD_SHOW, 14'd100,   MARK_NOOP,        1'b1, 16'h0000, 16'h0100},
        '{ssfg_pkg::CMD_SHOW, 14'd1000,  ssfg_pkg::MARK_H, 1'b1, 16'h0837, 16'h0100},
        '{ssfg_pkg::CMD_SHOW, 14'd1,     MARK_OTHER,       1'b1, 16'h0000, 16'h0101},
        '{ssfg_pkg::CMD_SHOW, 14'd8192,  ssfg_pkg::MARK_C, 1'b1, 16'h084E, 16'h0102},
        '{ssfg_pkg::CMD_SHOW, 14'h2AAA,  ssfg_pkg::MARK_H, 1'b1, 16'h0837, 16'h0109},
        '{ssfg_pkg::CMD_SHOW, 14'h1555,  ssfg_pkg::MARK_C, 1'b1, 16'h084E, 16'h0101},
        '{ssfg_pkg::CMD_SHOW, 14'd1001,  ssfg_pkg::MARK_C, 1'b0, 16'h0000, 16'h0000},
        '{ssfg_pkg::CMD_SHOW, 14'd1010,  ssfg_pkg::MARK_H, 1'b0, 16'h0000, 16'h0000},
        '{ssfg_pkg::CMD_SHOW, 14'd505,   MARK_NOOP,        1'b0, 16'h0000, 16'h0000},
        '{ssfg_pkg::CMD_SHOW, 14'd4321,  MARK_OTHER,       1'b0, 16'h0000, 16'h0000},
        '{ssfg_pkg::CMD_SHOW, 14'd7,     ssfg_pkg::MARK_H, 1'b0, 16'h0000, 16'h0000},
        '{ssfg_pkg::CMD_INIT, 14'd16383, ssfg_pkg::MARK_C, 1'b0, 16'h0000, 16'h0000}
    };

    seven_segment_frame_generator dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_cmd       (i_cmd),
        .i_value     (i_value),
        .i_marker    (i_marker),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_frame     (o_frame),
        .o_last      (o_last),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // 100 MHz clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("[%0t] mismatch: %s got 0x%04h want 0x%04h", $time, what, got, want);
        err_count++;
    endtask

    function automatic void push_frame(input logic [3:0] addr, input logic [7:0] data,
                                       input bit is_last);
        t_disp_frame f;
        f.frame = {4'h0, addr, data};
        f.last  = is_last;
        pending_frames.push_back(f);
    endfunction

    // expected frame burst for one command beat
    task automatic predict_burst(input logic cmd, input logic [13:0] value,
                                 input logic [1:0] marker);
        logic [13:0] sat;
        logic [3:0]  dig [4];
        bit          leading;
        if (cmd == ssfg_pkg::CMD_INIT) begin
            push_frame(ssfg_pkg::REG_SHUTDOWN, ssfg_pkg::DATA_POWER_ON, 1'b0);
            push_frame(ssfg_pkg::REG_DECODE, cfg_decode, 1'b0);
            push_frame(ssfg_pkg::REG_TEST, ssfg_pkg::DATA_ZERO, 1'b0);
            push_frame(ssfg_pkg::REG_SCANLIM, {5'd0, cfg_scan}, 1'b0);
            push_frame(ssfg_pkg::REG_INTENSITY, {4'd0, cfg_intensity}, 1'b0);
            for (int d = 1; d <= 4; d++) begin
                push_frame(4'(d), {4'd0, ssfg_pkg::CODE_BLANK}, 1'b0);
            end
            for (int d = 5; d <= 8; d++) begin
                push_frame(4'(d), ssfg_pkg::DATA_ZERO, d == 8);
            end
        end else begin
            sat    = (value > ssfg_pkg::VALUE_MAX) ? ssfg_pkg::VALUE_MAX : value;
            dig[0] = 4'(sat / 1000);
            dig[1] = 4'((sat / 100) % 10);
            dig[2] = 4'((sat / 10) % 10);
            dig[3] = 4'(sat % 10);
            case (marker)
                ssfg_pkg::MARK_H: push_frame(ssfg_pkg::REG_DIGIT8, ssfg_pkg::GLYPH_H, 1'b0);
                ssfg_pkg::MARK_C: push_frame(ssfg_pkg::REG_DIGIT8, ssfg_pkg::GLYPH_C, 1'b0);
                default:          push_frame(ssfg_pkg::REG_NOOP, ssfg_pkg::DATA_ZERO, 1'b0);
            endcase
            // thousands down to units, zeros blanked only while leading
            leading = 1'b1;
            for (int i = 0; i < 4; i++) begin
                if (i < 3 && leading && dig[i] == 4'd0) begin
                    push_frame(4'(4 - i), {4'd0, ssfg_pkg::CODE_BLANK}, 1'b0);
                end else begin
                    leading = 1'b0;
                    push_frame(4'(4 - i), {4'd0, dig[i]}, i == 3);
                end
            end
        end
    endtask

    // offer one beat, returns the queue position of its first expected frame
    task automatic send_item(input logic cmd, input logic [13:0] value,
                             input logic [1:0] marker, output int first_pos);
        int gap_pct;
        case (idle_mode)
            IDLE_SEND: gap_pct = 74;
            IDLE_BOTH: gap_pct = 24;
            default:   gap_pct = 0;
        endcase
        if ($urandom_range(99) < gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < gap_pct) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_cmd      <= cmd;
        i_value    <= value;
        i_marker   <= marker;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        first_pos = pending_frames.size();
        predict_burst(cmd, value, marker);
        beats_sent++;
        if (cmd == ssfg_pkg::CMD_INIT) inits_sent++;
    endtask

    task automatic send_random_item();
        logic [13:0] value;
        int          first_pos;
        case ($urandom_range(3))
            0:       value = 14'($urandom_range(16383));
            1:       value = 14'($urandom_range(9999));
            2:       value = 14'($urandom_range(99));
            default: value = 14'($urandom_range(9));
        endcase
        send_item(1'($urandom_range(1)), value, 2'($urandom_range(3)), first_pos);
    endtask

    task automatic write_reg(input logic [1:0] index, input logic [7:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (index)
            ssfg_pkg::CFG_INTENSITY:   cfg_intensity = data[3:0];
            ssfg_pkg::CFG_SCAN_LIMIT:  cfg_scan      = data[2:0];
            ssfg_pkg::CFG_DECODE_MASK: cfg_decode    = data;
            default: ;
        endcase
        reg_writes++;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // wait until every expected frame is out, then let the pipe settle
    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending_frames.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // receiver stall, with one long hold-off at the start of the pressure set
    always @(posedge i_clk) begin
        if (idle_mode == IDLE_PRESSURE && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            case (idle_mode)
                IDLE_RECV: i_out_stall <= ($urandom_range(99) < 74);
                IDLE_BOTH: i_out_stall <= ($urandom_range(99) < 24);
                default:   i_out_stall <= 1'b0;
            endcase
        end
    end

    // frame checker
    always @(posedge i_clk) begin : frame_check
        t_disp_frame want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_frames.size() == 0) begin
                report_mismatch("unexpected frame", o_frame, 16'h0000);
            end else begin
                want = pending_frames.pop_front();
                if (o_frame !== want.frame) report_mismatch("frame", o_frame, want.frame);
                if (o_last !== want.last) report_mismatch("last", 16'(o_last), 16'(want.last));
                frames_seen++;
            end
        end
    end

    // run limit
    initial begin
        #(RUN_LIMIT_NS);
        $display("timeout with %0d frames outstanding", pending_frames.size());
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        int         first_pos;
        logic [7:0] set_int;
        logic [7:0] set_scan;
        logic [7:0] set_dec;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table on reset settings, no idling
        for (int r = 0; r < NUM_ROWS; r++) begin
            send_item(directed_rows[r].cmd, directed_rows[r].value,
                      directed_rows[r].marker, first_pos);
            if (directed_rows[r].typed) begin
                pending_frames[first_pos].frame     = directed_rows[r].mark;
                pending_frames[first_pos + 4].frame = directed_rows[r].units;
            end
        end
        drain();

        // register settings, each followed by a random set under its own idling mix
        for (int s = 0; s < 5; s++) begin
            case (s)
                0: begin
                    set_int = 8'h0F; set_scan = 8'h00; set_dec = 8'hFF;
                end
                1: begin
                    set_int = 8'h00; set_scan = 8'h07; set_dec = 8'h00;
                end
                2: begin
                    // upper bits beyond the intensity and scan limit widths are dropped
                    set_int = 8'hF3; set_scan = 8'hFA; set_dec = 8'hA5;
                end
                default: begin
                    set_int  = 8'($urandom_range(255));
                    set_scan = 8'($urandom_range(255));
                    set_dec  = 8'($urandom_range(255));
                end
            endcase
            write_reg(ssfg_pkg::CFG_INTENSITY, set_int);
            write_reg(ssfg_pkg::CFG_SCAN_LIMIT, set_scan);
            write_reg(ssfg_pkg::CFG_DECODE_MASK, set_dec);
            write_reg(CFG_UNUSED, 8'($urandom_range(255)));
            case (s)
                0:       idle_mode = IDLE_NONE;
                1:       idle_mode = IDLE_SEND;
                2:       idle_mode = IDLE_RECV;
                3:       idle_mode = IDLE_BOTH;
                default: idle_mode = IDLE_PRESSURE;
            endcase
            repeat (ITEMS_PER_SET) send_random_item();
            drain();
        end

        if (pending_frames.size() != 0) begin
            report_mismatch("frames never seen", 16'(pending_frames.size()), 16'h0000);
        end
        $display("run: %0d command beats (%0d init), %0d frames checked, %0d register writes",
                 beats_sent, inits_sent, frames_seen, reg_writes);
        $display("run: saturation, marker codes, blanking, five register sets, stall mixes");
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
